@@ hw/rtl/wav_pcm_stream_parser_core_assert.svh @@
// ----------------------------------------------------------------------------
// wav pcm stream parser assertion macros
// concurrent checks clocked on i_clk, masked while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef WAV_PCM_STREAM_PARSER_CORE_ASSERT_SVH
`define WAV_PCM_STREAM_PARSER_CORE_ASSERT_SVH

// implication property under reset
`define WPSP_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication under reset
`define WPSP_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hw/rtl/wpsp_pkg.sv @@
// ----------------------------------------------------------------------------
// wpsp_pkg
// shared types and constants of the wav pcm stream parser
// ----------------------------------------------------------------------------
package wpsp_pkg;

    localparam logic [1:0] KIND_HDR    = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_FMT    = 2'd2;
    localparam logic [1:0] KIND_TRUNC  = 2'd3;

    localparam logic [31:0] TAG_DATA   = 32'h6174_6164;
    localparam logic [31:0] RIFF_WORD  = 32'h4646_4952;
    localparam logic [63:0] WAVE_WORD  = 64'h2074_6D66_4556_4157;

    localparam int QUEUE_DEPTH = 2;

    // one queued word from the front end
    typedef struct packed {
        logic        chk;
        logic [1:0]  kind;
        logic [15:0] chan_cnt;
        logic [31:0] rate;
        logic [4:0]  bits;
        logic [15:0] ch_idx;
        logic [15:0] smp;
        logic        fin;
    } t_rec;

    // header fields held by the front end while a check runs
    typedef struct packed {
        logic        magic_ok;
        logic        tag_data;
        logic        tag_pcm;
        logic [15:0] chan;
        logic [31:0] rate;
        logic [31:0] byte_rate;
        logic [15:0] align;
        logic [15:0] bits;
        logic [31:0] len;
    } t_hdr;

    typedef struct packed {
        logic done;
        logic ok;
    } t_rsp;

endpackage

@@ hw/rtl/wav_pcm_stream_parser_core.sv @@
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser_core
// wav riff pcm parser: file bytes in, header status and q1.15 samples out
// ----------------------------------------------------------------------------
//  channel  dir  tdata                         tuser  tlast
//  s        in   byte [7:0]                    -      last byte of file
//  m        out  chan/rate/bits/index/sample   kind   last word of file
//
//  one byte per cycle in header, skip, chunk and data phases unless queue full
//  after the byte that completes the header, input waits for the checks:
//  one product, one multiply and a 32-step serial modulo in the back end
//  synchronous active-low reset; a two-word queue and the output register
//  let input and output stall on their own
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // in_byte [7:0]
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // channel_count [15:0], rate_hz [47:16], sample_bits [52:48],
    // channel_index [68:53], sample_q15 [84:69], zero [87:85]
    output logic [87:0] o_m_tdata,
    output logic [1:0]  o_m_tuser,   // kind [1:0]
    output logic        o_m_tlast
);
    logic           w_push;
    logic           w_full;
    logic           w_q_valid;
    logic           w_pop;
    wpsp_pkg::t_rec w_rec_in;
    wpsp_pkg::t_rec w_rec_out;
    wpsp_pkg::t_hdr w_hdr;
    wpsp_pkg::t_rsp w_rsp;
    logic [15:0]    w_chan_cnt;
    logic [31:0]    w_rate;
    logic [4:0]     w_bits;
    logic [15:0]    w_ch_idx;
    logic [15:0]    w_smp;

    wpsp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_rec    (w_rec_in),
        .o_hdr    (w_hdr),
        .i_rsp    (w_rsp)
    );

    wpsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_rec   (w_rec_out),
        .i_pop   (w_pop)
    );

    wpsp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_rec      (w_rec_out),
        .o_pop      (w_pop),
        .i_hdr      (w_hdr),
        .o_rsp      (w_rsp),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_kind     (o_m_tuser),
        .o_chan_cnt (w_chan_cnt),
        .o_rate     (w_rate),
        .o_bits     (w_bits),
        .o_ch_idx   (w_ch_idx),
        .o_smp      (w_smp),
        .o_fin      (o_m_tlast)
    );

    assign o_m_tdata = {3'd0, w_smp, w_ch_idx, w_bits, w_rate, w_chan_cnt};
endmodule

@@ hw/rtl/wpsp_queue.sv @@
// ----------------------------------------------------------------------------
// wpsp_queue
// two-entry word queue between front end and back end
// ----------------------------------------------------------------------------
module wpsp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wpsp_pkg::t_rec i_rec,
    output logic           o_full,
    output logic           o_valid,
    output wpsp_pkg::t_rec o_rec,
    input  logic           i_pop
);
    wpsp_pkg::t_rec r_mem [wpsp_pkg::QUEUE_DEPTH];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'(wpsp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

@@ hw/rtl/wpsp_front.sv @@
// ----------------------------------------------------------------------------
// wpsp_front
// byte parser: header fields, chunk search, sample assembly
// ----------------------------------------------------------------------------
module wpsp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    input  logic           i_q_full,
    output logic           o_push,
    output wpsp_pkg::t_rec o_rec,
    output wpsp_pkg::t_hdr o_hdr,
    input  wpsp_pkg::t_rsp i_rsp
);
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_CHUNK  = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_WAIT   = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [5:0]  r_pos, n_pos;
    logic [31:0] r_fmt_len, n_fmt_len;
    logic [15:0] r_fmt_tag, n_fmt_tag;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [31:0] r_byte_rate, n_byte_rate;
    logic [15:0] r_align, n_align;
    logic [15:0] r_bits, n_bits;
    logic        r_magic_ok, n_magic_ok;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [31:0] r_left, n_left;
    logic [15:0] r_cur_ch, n_cur_ch;
    logic [7:0]  r_low, n_low;
    logic [31:0] r_skip, n_skip;
    logic        r_wait_last, n_wait_last;

    logic        w_acc;
    logic        w_clr;
    logic        w_trunc;
    logic        w_finish;
    logic [16:0] w_ch_inc;

    assign o_ready = (r_phase != PH_WAIT) && !i_q_full;
    assign w_acc   = i_valid && o_ready;

    assign o_hdr.magic_ok  = r_magic_ok;
    assign o_hdr.tag_data  = (r_tag == wpsp_pkg::TAG_DATA);
    assign o_hdr.tag_pcm   = (r_fmt_tag == 16'd1);
    assign o_hdr.chan      = r_chan;
    assign o_hdr.rate      = r_rate;
    assign o_hdr.byte_rate = r_byte_rate;
    assign o_hdr.align     = r_align;
    assign o_hdr.bits      = r_bits;
    assign o_hdr.len       = r_len;

    assign w_ch_inc = {1'b0, r_cur_ch} + 17'd1;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_fmt_len   = r_fmt_len;
        n_fmt_tag   = r_fmt_tag;
        n_chan      = r_chan;
        n_rate      = r_rate;
        n_byte_rate = r_byte_rate;
        n_align     = r_align;
        n_bits      = r_bits;
        n_magic_ok  = r_magic_ok;
        n_tag       = r_tag;
        n_len       = r_len;
        n_left      = r_left;
        n_cur_ch    = r_cur_ch;
        n_low       = r_low;
        n_skip      = r_skip;
        n_wait_last = r_wait_last;
        w_trunc     = 1'b0;
        w_finish    = 1'b0;
        o_push      = 1'b0;
        o_rec.chk      = 1'b0;
        o_rec.kind     = wpsp_pkg::KIND_TRUNC;
        o_rec.ch_idx   = 16'd0;
        o_rec.smp      = 16'd0;
        o_rec.fin      = 1'b1;

        if (w_acc) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos < 6'd4) begin
                        if (i_byte != wpsp_pkg::RIFF_WORD[8*r_pos[1:0] +: 8]) begin
                            n_magic_ok = 1'b0;
                        end
                    end else if (r_pos >= 6'd8 && r_pos < 6'd16) begin
                        if (i_byte != wpsp_pkg::WAVE_WORD[8*r_pos[2:0] +: 8]) begin
                            n_magic_ok = 1'b0;
                        end
                    end else if (r_pos >= 6'd16 && r_pos < 6'd20) begin
                        n_fmt_len[8*r_pos[1:0] +: 8] = i_byte;
                    end else if (r_pos >= 6'd20 && r_pos < 6'd22) begin
                        n_fmt_tag[8*r_pos[0] +: 8] = i_byte;
                    end else if (r_pos >= 6'd22 && r_pos < 6'd24) begin
                        n_chan[8*r_pos[0] +: 8] = i_byte;
                    end else if (r_pos >= 6'd24 && r_pos < 6'd28) begin
                        n_rate[8*r_pos[1:0] +: 8] = i_byte;
                    end else if (r_pos >= 6'd28 && r_pos < 6'd32) begin
                        n_byte_rate[8*r_pos[1:0] +: 8] = i_byte;
                    end else if (r_pos >= 6'd32 && r_pos < 6'd34) begin
                        n_align[8*r_pos[0] +: 8] = i_byte;
                    end else if (r_pos >= 6'd34 && r_pos < 6'd36) begin
                        n_bits[8*r_pos[0] +: 8] = i_byte;
                    end else if (r_pos >= 6'd36 && r_pos < 6'd40) begin
                        n_tag[8*r_pos[1:0] +: 8] = i_byte;
                    end else if (r_pos >= 6'd40) begin
                        n_len[8*r_pos[1:0] +: 8] = i_byte;
                    end
                    if (r_pos == 6'd35 && r_fmt_len > 32'd16) begin
                        n_skip  = r_fmt_len - 32'd16;
                        n_phase = PH_SKIP;
                        w_trunc = i_last;
                    end else if (r_pos >= 6'd43) begin
                        w_finish = 1'b1;
                    end else begin
                        n_pos   = r_pos + 6'd1;
                        w_trunc = i_last;
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 32'd1;
                    if (n_skip == 32'd0) begin
                        n_phase = PH_CHUNK;
                        n_pos   = 6'd0;
                    end
                    w_trunc = i_last;
                end
                PH_CHUNK: begin
                    if (r_pos == 6'd0) begin
                        n_tag = 32'd0;
                        n_len = 32'd0;
                    end
                    if (r_pos < 6'd4) begin
                        n_tag[8*r_pos[1:0] +: 8] = i_byte;
                    end else begin
                        n_len[8*r_pos[1:0] +: 8] = i_byte;
                    end
                    if (r_pos >= 6'd7) begin
                        n_pos = 6'd0;
                        if (n_tag == wpsp_pkg::TAG_DATA) begin
                            w_finish = 1'b1;
                        end else begin
                            if (n_len != 32'd0) begin
                                n_skip  = n_len;
                                n_phase = PH_SKIP;
                            end
                            w_trunc = i_last;
                        end
                    end else begin
                        n_pos   = r_pos + 6'd1;
                        w_trunc = i_last;
                    end
                end
                PH_DATA: begin
                    n_left = r_left - 32'd1;
                    if (r_bits == 16'd16 && !r_pos[0]) begin
                        n_low    = i_byte;
                        n_pos[0] = 1'b1;
                        w_trunc  = i_last;
                    end else begin
                        o_push = 1'b1;
                        if (r_bits == 16'd16) begin
                            n_pos[0]  = 1'b0;
                            o_rec.smp = {i_byte, r_low};
                        end else begin
                            o_rec.smp = {~i_byte[7], i_byte[6:0], 8'd0};
                        end
                        n_cur_ch = (w_ch_inc >= {1'b0, r_chan}) ? 16'd0 : w_ch_inc[15:0];
                        if (n_left == 32'd0) begin
                            o_rec.kind   = wpsp_pkg::KIND_SAMPLE;
                            o_rec.ch_idx = r_cur_ch;
                            n_phase      = PH_DONE;
                        end else if (i_last) begin
                            o_rec.smp = 16'd0;
                        end else begin
                            o_rec.kind   = wpsp_pkg::KIND_SAMPLE;
                            o_rec.ch_idx = r_cur_ch;
                            o_rec.fin    = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (w_trunc) begin
                o_push = 1'b1;
            end
            // header complete: hand the checks to the back end and hold still
            if (w_finish) begin
                o_push      = 1'b1;
                o_rec.chk   = 1'b1;
                o_rec.kind  = wpsp_pkg::KIND_HDR;
                o_rec.fin   = i_last;
                n_phase     = PH_WAIT;
                n_wait_last = i_last;
            end
        end

        // header values as they stand after this byte
        o_rec.chan_cnt = n_chan;
        o_rec.rate     = n_rate;
        o_rec.bits     = n_bits[4:0];

        if (r_phase == PH_WAIT && i_rsp.done && !r_wait_last) begin
            if (!i_rsp.ok || r_len == 32'd0) begin
                n_phase = PH_DONE;
            end else begin
                n_phase  = PH_DATA;
                n_pos    = 6'd0;
                n_cur_ch = 16'd0;
                n_left   = r_len;
            end
        end
    end

    assign w_clr = (w_acc && i_last && !w_finish) ||
                   (r_phase == PH_WAIT && i_rsp.done && r_wait_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr) begin
            r_phase     <= PH_HEADER;
            r_pos       <= 6'd0;
            r_fmt_len   <= 32'd0;
            r_fmt_tag   <= 16'd0;
            r_chan      <= 16'd0;
            r_rate      <= 32'd0;
            r_byte_rate <= 32'd0;
            r_align     <= 16'd0;
            r_bits      <= 16'd0;
            r_magic_ok  <= 1'b1;
            r_tag       <= 32'd0;
            r_len       <= 32'd0;
            r_left      <= 32'd0;
            r_cur_ch    <= 16'd0;
            r_low       <= 8'd0;
            r_skip      <= 32'd0;
            r_wait_last <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_fmt_len   <= n_fmt_len;
            r_fmt_tag   <= n_fmt_tag;
            r_chan      <= n_chan;
            r_rate      <= n_rate;
            r_byte_rate <= n_byte_rate;
            r_align     <= n_align;
            r_bits      <= n_bits;
            r_magic_ok  <= n_magic_ok;
            r_tag       <= n_tag;
            r_len       <= n_len;
            r_left      <= n_left;
            r_cur_ch    <= n_cur_ch;
            r_low       <= n_low;
            r_skip      <= n_skip;
            r_wait_last <= n_wait_last;
        end
    end
endmodule

@@ hw/rtl/wpsp_back.sv @@
// ----------------------------------------------------------------------------
// wpsp_back
// result stage: header checks (product, multiply, serial modulo) and output
// ----------------------------------------------------------------------------
`include "wav_pcm_stream_parser_core_assert.svh"

module wpsp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  wpsp_pkg::t_rec i_rec,
    output logic           o_pop,
    input  wpsp_pkg::t_hdr i_hdr,
    output wpsp_pkg::t_rsp o_rsp,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_kind,
    output logic [15:0]    o_chan_cnt,
    output logic [31:0]    o_rate,
    output logic [4:0]     o_bits,
    output logic [15:0]    o_ch_idx,
    output logic [15:0]    o_smp,
    output logic           o_fin
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]  r_state;
    logic [4:0]  r_cnt;
    logic        r_last;
    logic [31:0] r_prod;
    logic [31:0] r_mul;
    logic [31:0] r_dvd;
    logic [15:0] r_rem;

    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_chan_cnt;
    logic [31:0] r_rate;
    logic [4:0]  r_bits;
    logic [15:0] r_ch_idx;
    logic [15:0] r_smp;
    logic        r_fin;

    logic        w_out_free;
    logic [31:0] w_frame;
    logic [16:0] w_trial;
    logic [16:0] w_sub;
    logic        w_ok;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_pop      = (r_state == ST_IDLE) && i_q_valid && w_out_free;
    assign w_frame    = {3'd0, r_prod[31:3]};
    assign w_trial    = {r_rem, r_dvd[31]};
    assign w_sub      = w_trial - {1'b0, i_hdr.align};

    assign w_ok = i_hdr.magic_ok && i_hdr.tag_data && i_hdr.tag_pcm &&
                  (i_hdr.byte_rate == r_mul) &&
                  ({16'd0, i_hdr.align} == w_frame) && (i_hdr.align != 16'd0) &&
                  (r_rem == 16'd0) &&
                  (i_hdr.bits == 16'd8 || i_hdr.bits == 16'd16);

    assign o_rsp.done = (r_state == ST_EMIT) && w_out_free;
    assign o_rsp.ok   = w_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        if (i_rec.chk) begin
                            r_state <= ST_MUL;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                ST_MUL: begin
                    r_state <= ST_DIV;
                    r_cnt   <= 5'd0;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= ST_EMIT;
                        r_cnt   <= 5'd0;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_last     <= i_rec.fin;
                    r_prod     <= {16'd0, i_hdr.chan} * {16'd0, i_hdr.bits};
                    r_kind     <= i_rec.kind;
                    r_chan_cnt <= i_rec.chan_cnt;
                    r_rate     <= i_rec.rate;
                    r_bits     <= i_rec.bits;
                    r_ch_idx   <= i_rec.ch_idx;
                    r_smp      <= i_rec.smp;
                    r_fin      <= i_rec.fin;
                end
            end
            ST_MUL: begin
                r_mul <= w_frame * i_hdr.rate;
                r_dvd <= i_hdr.len;
                r_rem <= 16'd0;
            end
            ST_DIV: begin
                // one quotient bit per cycle, only the remainder is kept
                r_dvd <= {r_dvd[30:0], 1'b0};
                if (w_trial >= {1'b0, i_hdr.align}) begin
                    r_rem <= w_sub[15:0];
                end else begin
                    r_rem <= w_trial[15:0];
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    r_chan_cnt <= i_hdr.chan;
                    r_rate     <= i_hdr.rate;
                    r_bits     <= i_hdr.bits[4:0];
                    r_ch_idx   <= 16'd0;
                    r_smp      <= 16'd0;
                    if (!w_ok) begin
                        r_kind <= wpsp_pkg::KIND_FMT;
                        r_fin  <= 1'b1;
                    end else if (i_hdr.len == 32'd0) begin
                        r_kind <= wpsp_pkg::KIND_HDR;
                        r_fin  <= 1'b1;
                    end else if (r_last) begin
                        r_kind <= wpsp_pkg::KIND_TRUNC;
                        r_fin  <= 1'b1;
                    end else begin
                        r_kind <= wpsp_pkg::KIND_HDR;
                        r_fin  <= 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_kind;
    assign o_chan_cnt = r_chan_cnt;
    assign o_rate     = r_rate;
    assign o_bits     = r_bits;
    assign o_ch_idx   = r_ch_idx;
    assign o_smp      = r_smp;
    assign o_fin      = r_fin;

    `WPSP_ASSERT_IMP(a_cnt_div_only, r_state != ST_DIV, r_cnt == 5'd0, "modulo count outside divide")
    `WPSP_ASSERT_NXT(a_rsp_pulse, o_rsp.done, !o_rsp.done, "check response longer than one cycle")
    `WPSP_ASSERT_IMP(a_nonsample_zero, r_out_valid && r_kind != wpsp_pkg::KIND_SAMPLE, r_ch_idx == 16'd0 && r_smp == 16'd0, "non-sample word carries sample data")
endmodule
